// ===== rtl/ices_pkg.sv =====
// ---------------------------------------------------------------------------
// ices_pkg
// Shared types and constants of the injector close event scheduler.
// ---------------------------------------------------------------------------
package ices_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_FIRES  = 4;
    localparam int FIRE_W     = $clog2(MAX_FIRES + 1);
    localparam int FSLOT_W    = 2;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 8;
    localparam int MARGIN_W   = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd4;
    localparam logic [CNT_W-1:0]    CNT_MAX      = 8'd255;

    typedef enum logic [1:0] {
        MODE_SCHED   = 2'd0,
        MODE_CANCEL  = 2'd1,
        MODE_COMPARE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [CNT_W-1:0]  pending;
    } t_slot;

    typedef struct packed {
        t_mode               mode;
        logic                hit;
        logic                fire_ok;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   delay;
        logic [MARGIN_W-1:0] margin;
    } t_upd_ctl;

    // True when (int32)(a - b) >= 0.
    function automatic logic reached(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return ~d[TIME_W-1];
    endfunction

endpackage

// ===== rtl/ices_slot_mem.sv =====
// ---------------------------------------------------------------------------
// ices_slot_mem
// Slot state memory with one write port, one registered read port and a
// valid bit per entry so that unwritten entries read as a free slot.
// ---------------------------------------------------------------------------
module ices_slot_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [ices_pkg::SLOT_W-1:0] i_waddr,
    input  ices_pkg::t_slot       i_wdata,
    input  logic                  i_re,
    input  logic [ices_pkg::SLOT_W-1:0] i_raddr,
    output ices_pkg::t_slot       o_rdata
);
    import ices_pkg::*;

    t_slot                 mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_vld;
    t_slot                 r_rdata;
    logic                  r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== rtl/ices_slot_update.sv =====
// ---------------------------------------------------------------------------
// ices_slot_update
// Next state of one slot for a schedule, cancel or compare event word.
// ---------------------------------------------------------------------------
module ices_slot_update (
    input  ices_pkg::t_upd_ctl i_ctl,
    input  ices_pkg::t_slot    i_slot,
    output ices_pkg::t_slot    o_slot,
    output logic               o_fired
);
    import ices_pkg::*;

    logic [TIME_W-1:0] sched_t;
    logic [TIME_W-1:0] diff_t;
    logic [CNT_W-1:0]  dec_cnt;
    logic              busy;

    assign busy    = (i_slot.pending != '0);
    assign sched_t = i_ctl.now + i_ctl.delay;
    assign diff_t  = sched_t - i_slot.deadline;
    assign dec_cnt = i_slot.pending - CNT_W'(1);

    always_comb begin
        o_slot  = i_slot;
        o_fired = 1'b0;
        case (i_ctl.mode)
            MODE_SCHED: begin
                if (i_ctl.hit && (i_ctl.delay != '0)) begin
                    if (!busy) begin
                        o_slot.deadline = sched_t;
                        o_slot.pending  = CNT_W'(1);
                    end else begin
                        if ((diff_t != '0) && !diff_t[TIME_W-1]) begin
                            o_slot.deadline = sched_t;
                        end
                        if (i_slot.pending != CNT_MAX) begin
                            o_slot.pending = i_slot.pending + CNT_W'(1);
                        end
                    end
                end
            end
            MODE_CANCEL: begin
                if (i_ctl.hit) begin
                    o_slot.pending = '0;
                end
            end
            MODE_COMPARE: begin
                if (busy && i_ctl.fire_ok && reached(i_ctl.now, i_slot.deadline)) begin
                    o_fired        = 1'b1;
                    o_slot.pending = dec_cnt;
                    if (dec_cnt != '0) begin
                        o_slot.deadline = i_ctl.now + TIME_W'(i_ctl.margin);
                    end
                end
            end
            default: begin
                o_slot  = i_slot;
                o_fired = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/injector_close_event_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// injector_close_event_scheduler_unit
// Per-cylinder close slot scheduler with compare target reporting.
// ---------------------------------------------------------------------------
// The input stream carries one command word: tuser holds the mode (schedule,
// cancel or compare event) and tdata holds the slot, the current time and the
// delay. For each word the slot memory is walked once, one slot per cycle,
// reading, updating and writing back each entry while the earliest pending
// deadline is tracked. A word is accepted when the block is idle; each slot
// is read through the registered memory read port, then updated and written
// back, and after the walk the first result is loaded into the output
// register. A compare event gives one result per fired slot, and every word
// gives at least one result; the results are loaded in turn, and the next
// word is accepted only after the last result is loaded. The output register
// lets a new word enter while the previous final result still waits. When
// the receiver stalls, the output word holds and the result walk pauses.
// Reset frees all slots, restores the refire margin to four ticks and empties
// the output register.
// ---------------------------------------------------------------------------
module injector_close_event_scheduler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ices_pkg::MARGIN_W-1:0]      i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // slot_index[1:0], time_now[33:2], delay_ticks[65:34], zero fill above.
    input  logic [ices_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode[1:0].
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fired_slot[1:0], compare_armed[2], compare_value[34:3], force_now[35].
    output logic [ices_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // fired[0].
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import ices_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_ADDR = SLOT_W'(NUM_SLOTS - 1);
    localparam int                CMP_W     = (SLOT_W > 2) ? SLOT_W : 2;

    t_state              r_state;
    logic [MARGIN_W-1:0] r_margin;
    t_mode               r_mode;
    logic [1:0]          r_idx;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_delay;
    logic [SLOT_W-1:0]   r_rd_addr;
    logic                r_rd_more;
    logic                r_proc_vld;
    logic [SLOT_W-1:0]   r_proc_addr;
    logic                r_found;
    logic [TIME_W-1:0]   r_earliest;
    logic [FIRE_W-1:0]   r_nfire;
    logic [FSLOT_W-1:0]  r_fire_list [MAX_FIRES];
    logic [FIRE_W-1:0]   r_emit_k;
    logic                r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic                r_o_user;
    logic                r_o_last;

    t_upd_ctl            upd_ctl;
    t_slot               rd_slot;
    t_slot               wr_slot;
    logic                upd_fired;
    logic                accept;
    logic                mem_re;
    logic                out_load_ok;
    logic                emit_last;
    logic                fold_take;
    logic [TIME_W-1:0]   fold_diff;
    logic [TIME_W-1:0]   cmp_value;
    logic                force_now;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign mem_re        = (r_state == ST_SCAN) && r_rd_more;
    assign out_load_ok   = !r_o_valid || m_axis_tready;

    assign upd_ctl.mode    = r_mode;
    assign upd_ctl.hit     = (CMP_W'(r_proc_addr) == CMP_W'(r_idx));
    assign upd_ctl.fire_ok = (r_nfire < FIRE_W'(MAX_FIRES));
    assign upd_ctl.now     = r_now;
    assign upd_ctl.delay   = r_delay;
    assign upd_ctl.margin  = r_margin;

    ices_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_proc_vld),
        .i_waddr (r_proc_addr),
        .i_wdata (wr_slot),
        .i_re    (mem_re),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_slot)
    );

    ices_slot_update u_upd (
        .i_ctl   (upd_ctl),
        .i_slot  (rd_slot),
        .o_slot  (wr_slot),
        .o_fired (upd_fired)
    );

    assign fold_diff = wr_slot.deadline - r_earliest;
    assign fold_take = (wr_slot.pending != '0) && (!r_found || fold_diff[TIME_W-1]);

    assign cmp_value = r_found ? r_earliest : '0;
    assign force_now = r_found && reached(r_now, r_earliest);
    assign emit_last = (r_nfire == '0) || (r_emit_k == r_nfire - FIRE_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_more  <= 1'b0;
            r_proc_vld <= 1'b0;
            r_found    <= 1'b0;
            r_nfire    <= '0;
            r_emit_k   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (m_axis_tready && !((r_state == ST_EMIT) && out_load_ok)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mode      <= t_mode'(s_axis_tuser);
                        r_idx       <= s_axis_tdata[1:0];
                        r_now       <= s_axis_tdata[33:2];
                        r_delay     <= s_axis_tdata[65:34];
                        r_rd_addr   <= '0;
                        r_rd_more   <= 1'b1;
                        r_proc_vld  <= 1'b0;
                        r_found     <= 1'b0;
                        r_earliest  <= '0;
                        r_nfire     <= '0;
                        r_emit_k    <= '0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_proc_vld  <= r_rd_more;
                    r_proc_addr <= r_rd_addr;
                    if (r_rd_more) begin
                        r_rd_addr <= r_rd_addr + SLOT_W'(1);
                        r_rd_more <= (r_rd_addr != LAST_ADDR);
                    end
                    if (r_proc_vld) begin
                        if (fold_take) begin
                            r_found    <= 1'b1;
                            r_earliest <= wr_slot.deadline;
                        end
                        if (upd_fired) begin
                            r_fire_list[r_nfire[$clog2(MAX_FIRES)-1:0]] <=
                                r_proc_addr[FSLOT_W-1:0];
                            r_nfire <= r_nfire + FIRE_W'(1);
                        end
                        if (r_proc_addr == LAST_ADDR) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_load_ok) begin
                        r_o_valid <= 1'b1;
                        r_o_user  <= (r_nfire != '0);
                        r_o_last  <= emit_last;
                        r_o_data  <= {4'b0, force_now, cmp_value, r_found,
                                      (r_nfire != '0) ?
                                          r_fire_list[r_emit_k[$clog2(MAX_FIRES)-1:0]] :
                                          FSLOT_W'(0)};
                        r_emit_k  <= r_emit_k + FIRE_W'(1);
                        if (emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tlast  = r_o_last;

endmodule
